[rtl/xys_pkg.sv]
// ----------------------------------------------------------------------------
// xys_pkg
// Shared types, constants and elaboration-time functions for the xyY to sRGB
// converter: number formats, the color matrix and the transfer-curve table.
// ----------------------------------------------------------------------------
package xys_pkg;

    // Number formats.
    localparam int FRAC_BITS         = 16;
    localparam int GAMMA_TABLE_DEPTH = 1024;
    localparam int GLOG              = $clog2(GAMMA_TABLE_DEPTH);
    localparam int IN_W              = 17;
    localparam int OUT_W             = 20;
    localparam int XYZ_W             = FRAC_BITS + 5;
    localparam int LIN_W             = XYZ_W;
    localparam int Q_W               = FRAC_BITS + 5;
    localparam int DEN_W             = IN_W + 1;
    localparam int NUM_W             = 37;
    localparam int REM_W             = DEN_W + Q_W;
    localparam int COEF_W            = 33;
    localparam int PROD_W            = XYZ_W + COEF_W;
    localparam int SUM_W             = PROD_W + 2;
    localparam int GT_W              = FRAC_BITS + 2;
    localparam int GIDX_W            = GLOG + 1;
    localparam int GSH               = FRAC_BITS - GLOG;
    localparam int MAG_W             = 31;
    localparam int PRODL_W           = 63;
    localparam int RECIP_SH          = 38;
    localparam int G_W               = 26;

    localparam longint LIMIT_POS = (longint'(1) << (FRAC_BITS + 4)) - 1;
    localparam longint LIMIT_NEG = -(longint'(1) << (FRAC_BITS + 4));
    localparam longint ONE_F     = longint'(1) << FRAC_BITS;
    localparam longint GAMMA_THR = ((longint'(31308) << FRAC_BITS) + 5000000) / 10000000;
    localparam longint RECIP     = ((longint'(1) << RECIP_SH) + 99) / 100;
    localparam longint OUT_MAX   = 524287;
    localparam longint OUT_MIN   = -524288;

    // Configuration register addresses.
    localparam logic [2:0] ADDR_LUMINANCE = 3'd0;
    localparam logic [16:0] LUMINANCE_RESET = 17'd65536;

    typedef struct packed {
        logic [IN_W-1:0] chroma_x;
        logic [IN_W-1:0] chroma_y;
    } request_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] red;
        logic signed [OUT_W-1:0] green;
        logic signed [OUT_W-1:0] blue;
        logic                    clipped;
    } result_t;

    // Sideband that travels with each request through the divider.
    typedef struct packed {
        logic [IN_W-1:0] lum;
        logic            yzero;
        logic            zneg;
        logic            ovf_x;
        logic            ovf_z;
    } div_side_t;

    typedef logic signed [GT_W-1:0] gtab_t [0:GAMMA_TABLE_DEPTH];

    // Q2.30 matrix coefficient, rounded on the magnitude.
    function automatic logic signed [COEF_W-1:0] coef(longint n);
        longint m;
        longint r;
        m = (n < 0) ? -n : n;
        r = (m * (longint'(1) << 30) + 5000000) / 10000000;
        return COEF_W'((n < 0) ? -r : r);
    endfunction

    localparam logic signed [COEF_W-1:0] MAT [0:2][0:2] = '{
        '{coef(32404500),  coef(-15371400), coef(-4985320)},
        '{coef(-9692660),  coef(18760100),  coef(415561)},
        '{coef(556434),    coef(-2040260),  coef(10572300)}
    };

    function automatic longint unsigned isqrt64(longint unsigned x);
        longint unsigned res;
        longint unsigned bit_v;
        longint unsigned v;
        res   = 0;
        bit_v = 64'h4000000000000000;
        v     = x;
        while (bit_v > v)
            bit_v = bit_v >> 2;
        while (bit_v != 0)
        begin
            if (v >= res + bit_v)
            begin
                v   = v - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned icbrt64(longint unsigned x);
        longint unsigned y;
        longint unsigned b;
        longint unsigned v;
        int              s;
        y = 0;
        v = x;
        for (s = 63; s >= 0; s = s - 3)
        begin
            y = y << 1;
            b = 3 * y * (y + 1) + 1;
            if ((v >> s) >= b)
            begin
                v = v - (b << s);
                y = y + 1;
            end
        end
        return y;
    endfunction

    // One point of 1.055*u^(1/2.4) - 0.055 at u = i/GAMMA_TABLE_DEPTH.
    function automatic logic signed [GT_W-1:0] gtab_entry(int i);
        longint unsigned u;
        longint unsigned a;
        longint unsigned q;
        longint unsigned cb;
        longint unsigned p;
        longint          off30;
        longint          g;
        longint          r;
        longint          half;
        off30 = longint'(((64'd55 << 30) + 500) / 1000);
        u     = (longint'(i) << 30) / GAMMA_TABLE_DEPTH;
        a     = isqrt64(u << 30);
        q     = isqrt64(a << 30);
        cb    = icbrt64((a >> 10) << 40);
        p     = (q * cb + (64'd1 << 19)) >> 20;
        g     = longint'((p * 1055 + 500) / 1000) - off30;
        half  = longint'(1) << (30 - FRAC_BITS - 1);
        if (g < 0)
            r = -((-g + half) >>> (30 - FRAC_BITS));
        else
            r = (g + half) >>> (30 - FRAC_BITS);
        return GT_W'(r);
    endfunction

    function automatic gtab_t gtab_build();
        gtab_t t;
        for (int i = 0; i <= GAMMA_TABLE_DEPTH; i++)
            t[i] = gtab_entry(i);
        return t;
    endfunction

endpackage

[rtl/xys_divider.sv]
// ----------------------------------------------------------------------------
// xys_divider
// Pipelined restoring divider that forms the X and Z quotients over a shared
// denominator, one quotient bit per stage.
// ----------------------------------------------------------------------------
module xys_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      valid_in,
    input  logic [xys_pkg::NUM_W-1:0] num_x,
    input  logic [xys_pkg::NUM_W-1:0] num_z,
    input  logic [xys_pkg::DEN_W-1:0] den,
    input  xys_pkg::div_side_t        side_in,
    output logic                      valid_out,
    output logic [xys_pkg::Q_W-1:0]   qx,
    output logic [xys_pkg::Q_W-1:0]   qz,
    output xys_pkg::div_side_t        side_out
);
    import xys_pkg::*;

    logic [Q_W:0]       valid_reg;
    logic [NUM_W-1:0]   rem_x_reg [0:Q_W];
    logic [NUM_W-1:0]   rem_z_reg [0:Q_W];
    logic [DEN_W-1:0]   den_reg   [0:Q_W];
    logic [Q_W-1:0]     qx_reg    [0:Q_W];
    logic [Q_W-1:0]     qz_reg    [0:Q_W];
    div_side_t          side_reg  [0:Q_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[Q_W-1:0], valid_in};
    end

    always_ff @(posedge clk)
    begin
        rem_x_reg[0] <= num_x;
        rem_z_reg[0] <= num_z;
        den_reg[0]   <= den;
        qx_reg[0]    <= '0;
        qz_reg[0]    <= '0;
        side_reg[0]  <= side_in;
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        localparam int B = Q_W - 1 - k;
        logic [REM_W-1:0] dsh;
        logic             ge_x;
        logic             ge_z;
        logic [NUM_W-1:0] rem_x_next;
        logic [NUM_W-1:0] rem_z_next;

        always_comb
        begin
            dsh        = REM_W'(den_reg[k]) << B;
            ge_x       = REM_W'(rem_x_reg[k]) >= dsh;
            ge_z       = REM_W'(rem_z_reg[k]) >= dsh;
            rem_x_next = ge_x ? NUM_W'(REM_W'(rem_x_reg[k]) - dsh) : rem_x_reg[k];
            rem_z_next = ge_z ? NUM_W'(REM_W'(rem_z_reg[k]) - dsh) : rem_z_reg[k];
        end

        always_ff @(posedge clk)
        begin
            rem_x_reg[k+1] <= rem_x_next;
            rem_z_reg[k+1] <= rem_z_next;
            den_reg[k+1]   <= den_reg[k];
            qx_reg[k+1]    <= {qx_reg[k][Q_W-2:0], ge_x};
            qz_reg[k+1]    <= {qz_reg[k][Q_W-2:0], ge_z};
            side_reg[k+1]  <= side_reg[k];
        end
    end

    assign valid_out = valid_reg[Q_W];
    assign qx        = qx_reg[Q_W];
    assign qz        = qz_reg[Q_W];
    assign side_out  = side_reg[Q_W];

endmodule

[rtl/xys_matrix.sv]
// ----------------------------------------------------------------------------
// xys_matrix
// XYZ to linear sRGB matrix: products, sum, then rounding and saturation.
// ----------------------------------------------------------------------------
module xys_matrix (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             valid_in,
    input  logic                             clip_in,
    input  logic signed [xys_pkg::XYZ_W-1:0] xyz_in [3],
    output logic                             valid_out,
    output logic                             clip_out,
    output logic signed [xys_pkg::LIN_W-1:0] lin_out [3]
);
    import xys_pkg::*;

    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(longint'(1) << 29);

    logic [2:0]               valid_reg;
    logic [1:0]               clip_reg;
    logic                     clip_out_reg;
    logic signed [PROD_W-1:0] prod_reg [0:2][0:2];
    logic signed [SUM_W-1:0]  sum_reg  [0:2];
    logic signed [LIN_W-1:0]  lin_reg  [0:2];
    logic signed [LIN_W-1:0]  lin_next [0:2];
    logic [2:0]               sat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[1:0], valid_in};
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
                prod_reg[k][j] <= PROD_W'(xyz_in[j]) * PROD_W'(MAT[k][j]);
            sum_reg[k] <= SUM_W'(prod_reg[k][0]) + SUM_W'(prod_reg[k][1])
                        + SUM_W'(prod_reg[k][2]);
            lin_reg[k] <= lin_next[k];
        end
        clip_reg     <= {clip_reg[0], clip_in};
        clip_out_reg <= clip_reg[1] | (|sat_next);
    end

    // Round to nearest with ties away from zero, then limit to [-16, 16).
    always_comb
    begin
        logic signed [SUM_W-1:0] r;
        for (int k = 0; k < 3; k++)
        begin
            r = (sum_reg[k] + ((sum_reg[k] < 0) ? HALF - 1 : HALF)) >>> 30;
            if (r > SUM_W'(LIMIT_POS))
            begin
                lin_next[k] = LIN_W'(LIMIT_POS);
                sat_next[k] = 1'b1;
            end
            else if (r < SUM_W'(LIMIT_NEG))
            begin
                lin_next[k] = LIN_W'(LIMIT_NEG);
                sat_next[k] = 1'b1;
            end
            else
            begin
                lin_next[k] = LIN_W'(r);
                sat_next[k] = 1'b0;
            end
        end
    end

    assign valid_out = valid_reg[2];
    assign clip_out  = clip_out_reg;
    assign lin_out   = lin_reg;

endmodule

[rtl/xys_gamma.sv]
// ----------------------------------------------------------------------------
// xys_gamma
// sRGB transfer curve for one component: a scaled linear segment near zero
// and an interpolated table for the power segment, then output saturation.
// ----------------------------------------------------------------------------
module xys_gamma (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             valid_in,
    input  logic                             clip_in,
    input  logic signed [xys_pkg::LIN_W-1:0] lin_in,
    output logic                             valid_out,
    output logic                             clip_out,
    output logic signed [xys_pkg::OUT_W-1:0] comp_out
);
    import xys_pkg::*;

    localparam gtab_t GTAB = gtab_build();
    localparam logic signed [LIN_W-1:0] THR_S = LIN_W'(GAMMA_THR);
    localparam logic signed [LIN_W-1:0] ONE_S = LIN_W'(ONE_F);
    localparam logic [GIDX_W-1:0] IDX_LAST = GIDX_W'(GAMMA_TABLE_DEPTH);
    localparam int V_W = GT_W + GSH + 2;
    localparam logic signed [V_W-1:0] VHALF = V_W'(longint'(1) << (GSH - 1));

    logic [3:0]              valid_reg;
    logic [2:0]              clip_reg;
    logic                    clip_out_reg;
    // Stage one.
    logic                    lin_br_reg;
    logic                    neg_reg;
    logic [MAG_W-1:0]        m_reg;
    logic signed [GT_W-1:0]  lo_reg;
    logic signed [GT_W-1:0]  hi_reg;
    logic [GSH-1:0]          f_reg;
    // Stage two.
    logic                    lin_br2_reg;
    logic                    neg2_reg;
    logic [PRODL_W-1:0]      pl_reg;
    logic signed [GT_W:0]    diff_reg;
    logic signed [GT_W-1:0]  lo2_reg;
    logic [GSH-1:0]          f2_reg;
    // Stage three and four.
    logic signed [G_W-1:0]   g_reg;
    logic signed [OUT_W-1:0] comp_reg;

    logic                    lin_br;
    logic [LIN_W-1:0]        mag;
    logic [FRAC_BITS:0]      c;
    logic                    clamp;
    logic [GIDX_W-1:0]       idx;
    logic [GIDX_W-1:0]       idx1;
    logic signed [G_W-1:0]   g_next;
    logic signed [OUT_W-1:0] comp_next;
    logic                    osat;

    always_comb
    begin
        lin_br = lin_in <= THR_S;
        mag    = (lin_in < 0) ? LIN_W'(-lin_in) : LIN_W'(lin_in);
        clamp  = !lin_br && (lin_in > ONE_S);
        c      = clamp ? (FRAC_BITS+1)'(ONE_F) : lin_in[FRAC_BITS:0];
        idx    = c[FRAC_BITS:GSH];
        idx1   = (idx == IDX_LAST) ? idx : idx + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[2:0], valid_in};
    end

    always_ff @(posedge clk)
    begin
        clip_reg[0]  <= clip_in | clamp;
        lin_br_reg   <= lin_br;
        neg_reg      <= lin_in < 0;
        m_reg        <= MAG_W'(mag) * MAG_W'(1292);
        lo_reg       <= GTAB[idx];
        hi_reg       <= GTAB[idx1];
        f_reg        <= c[GSH-1:0];

        clip_reg[1]  <= clip_reg[0];
        lin_br2_reg  <= lin_br_reg;
        neg2_reg     <= neg_reg;
        pl_reg       <= PRODL_W'(m_reg + MAG_W'(50)) * PRODL_W'(RECIP);
        diff_reg     <= (GT_W+1)'(hi_reg) - (GT_W+1)'(lo_reg);
        lo2_reg      <= lo_reg;
        f2_reg       <= f_reg;

        clip_reg[2]  <= clip_reg[1];
        g_reg        <= g_next;

        clip_out_reg <= clip_reg[2] | osat;
        comp_reg     <= comp_next;
    end

    // Stage three: finish the divide by 100 or interpolate between points.
    always_comb
    begin
        logic [G_W-2:0]         q;
        logic signed [V_W-1:0]  v;
        logic signed [V_W-1:0]  r;
        q = pl_reg[PRODL_W-1:RECIP_SH];
        v = V_W'(diff_reg) * V_W'($signed({1'b0, f2_reg}));
        r = (v + ((v < 0) ? VHALF - 1 : VHALF)) >>> GSH;
        if (lin_br2_reg)
            g_next = neg2_reg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        else
            g_next = G_W'(lo2_reg) + G_W'(r);
    end

    // Stage four: limit to the output format.
    always_comb
    begin
        if (g_reg > G_W'(OUT_MAX))
        begin
            comp_next = OUT_W'(OUT_MAX);
            osat      = 1'b1;
        end
        else if (g_reg < G_W'(OUT_MIN))
        begin
            comp_next = OUT_W'(OUT_MIN);
            osat      = 1'b1;
        end
        else
        begin
            comp_next = OUT_W'(g_reg);
            osat      = 1'b0;
        end
    end

    assign valid_out = valid_reg[3];
    assign clip_out  = clip_out_reg;
    assign comp_out  = comp_reg;

endmodule

[rtl/xyy_to_srgb_converter.sv]
// ----------------------------------------------------------------------------
// xyy_to_srgb_converter
// CIE xyY chromaticity plus a programmed luminance to non-linear sRGB.
// ----------------------------------------------------------------------------
// A request (chroma_x, chroma_y) is taken on every cycle in which start is
// high; busy is always low, so one pixel per clock goes in and one result per
// clock comes out. Each request produces exactly one result, presented for a
// single cycle with done high. The 31 register stages are one for the
// products, one for the dividends at the divider input, 21 divider stages
// (one quotient bit each), one to saturate X and Z, three matrix stages and
// four transfer-curve stages, the last of which drives the result ports. The
// receiver cannot stall the pipeline, so results must be taken as they
// appear. The luminance register is sampled as each request is taken and
// should only be written while no request is in the pipeline.
// ----------------------------------------------------------------------------
module xyy_to_srgb_converter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  xys_pkg::request_t  request,
    output logic               done,
    output xys_pkg::result_t   result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import xys_pkg::*;

    // Configuration register. Writes complete on the access cycle.
    logic [IN_W-1:0] lum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lum_reg <= LUMINANCE_RESET;
        else if (psel && penable && pwrite && (paddr == ADDR_LUMINANCE))
            lum_reg <= pwdata[IN_W-1:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_LUMINANCE) ? 32'(lum_reg) : 32'd0;
    assign busy   = 1'b0;

    // Stage one: Y*x and Y*|1-x-y|. The sign of 1-x-y is kept for Z.
    logic signed [IN_W+1:0] n_val;
    logic [IN_W:0]          n_mag;

    always_comb
    begin
        n_val = (IN_W+2)'(65536) - $signed({2'b00, request.chroma_x})
              - $signed({2'b00, request.chroma_y});
        n_mag = (n_val < 0) ? (IN_W+1)'(-n_val) : (IN_W+1)'(n_val);
    end

    logic                  s1_valid_reg;
    logic [2*IN_W-1:0]     s1_px_reg;
    logic [2*IN_W:0]       s1_pz_reg;
    logic [IN_W-1:0]       s1_y_reg;
    logic [IN_W-1:0]       s1_lum_reg;
    logic                  s1_zneg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        s1_px_reg   <= (2*IN_W)'(lum_reg) * (2*IN_W)'(request.chroma_x);
        s1_pz_reg   <= (2*IN_W+1)'(lum_reg) * (2*IN_W+1)'(n_mag);
        s1_y_reg    <= request.chroma_y;
        s1_lum_reg  <= lum_reg;
        s1_zneg_reg <= n_val < 0;
    end

    // Rounded quotients: (2*N + y) / (2*y) truncated equals N/y rounded half
    // up. A dividend at or beyond den << Q_W cannot fit and saturates.
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_z;
    logic [DEN_W-1:0] den;
    div_side_t        side_in;

    always_comb
    begin
        num_x         = NUM_W'({s1_px_reg, 1'b0}) + NUM_W'(s1_y_reg);
        num_z         = NUM_W'({s1_pz_reg, 1'b0}) + NUM_W'(s1_y_reg);
        den           = {s1_y_reg, 1'b0};
        side_in.lum   = s1_lum_reg;
        side_in.yzero = s1_y_reg == '0;
        side_in.zneg  = s1_zneg_reg;
        side_in.ovf_x = REM_W'(num_x) >= (REM_W'(den) << Q_W);
        side_in.ovf_z = REM_W'(num_z) >= (REM_W'(den) << Q_W);
    end

    logic             div_valid;
    logic [Q_W-1:0]   qx;
    logic [Q_W-1:0]   qz;
    div_side_t        side_out;

    xys_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s1_valid_reg),
        .num_x     (num_x),
        .num_z     (num_z),
        .den       (den),
        .side_in   (side_in),
        .valid_out (div_valid),
        .qx        (qx),
        .qz        (qz),
        .side_out  (side_out)
    );

    // Saturate X and Z to [-16, 16). A zero y forces both to zero.
    logic signed [XYZ_W-1:0] x_next;
    logic signed [XYZ_W-1:0] z_next;
    logic                    xz_clip;

    always_comb
    begin
        logic big_x;
        logic big_z;
        big_x = side_out.ovf_x | qx[Q_W-1];
        if (side_out.zneg)
            big_z = side_out.ovf_z | (qz > Q_W'(-LIMIT_NEG));
        else
            big_z = side_out.ovf_z | qz[Q_W-1];

        if (side_out.yzero)
        begin
            x_next  = '0;
            z_next  = '0;
            xz_clip = 1'b0;
        end
        else
        begin
            x_next  = big_x ? XYZ_W'(LIMIT_POS) : $signed(qx);
            if (big_z)
                z_next = side_out.zneg ? XYZ_W'(LIMIT_NEG) : XYZ_W'(LIMIT_POS);
            else
                z_next = side_out.zneg ? -$signed(qz) : $signed(qz);
            xz_clip = big_x | big_z;
        end
    end

    logic                    s3_valid_reg;
    logic                    s3_clip_reg;
    logic signed [XYZ_W-1:0] s3_xyz_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        s3_clip_reg   <= xz_clip;
        s3_xyz_reg[0] <= x_next;
        s3_xyz_reg[1] <= $signed(XYZ_W'(side_out.lum));
        s3_xyz_reg[2] <= z_next;
    end

    logic                    mat_valid;
    logic                    mat_clip;
    logic signed [LIN_W-1:0] lin [3];

    xys_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s3_valid_reg),
        .clip_in   (s3_clip_reg),
        .xyz_in    (s3_xyz_reg),
        .valid_out (mat_valid),
        .clip_out  (mat_clip),
        .lin_out   (lin)
    );

    // One transfer-curve pipe per component; the earlier clip flag rides
    // along with the red pipe.
    logic [2:0]              g_valid;
    logic [2:0]              g_clip;
    logic signed [OUT_W-1:0] comp [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_comp
        xys_gamma u_gamma (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (mat_valid),
            .clip_in   ((k == 0) ? mat_clip : 1'b0),
            .lin_in    (lin[k]),
            .valid_out (g_valid[k]),
            .clip_out  (g_clip[k]),
            .comp_out  (comp[k])
        );
    end

    assign done = g_valid[0];

    always_comb
    begin
        result.red     = comp[0];
        result.green   = comp[1];
        result.blue    = comp[2];
        result.clipped = |g_clip;
    end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the xyY to sRGB converter. Requests carrying a
// chromaticity pair are driven under several idle patterns and luminance
// settings; an internal fixed-point predictor computes each expected color,
// and a scoreboard compares every result against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import xys_pkg::*;

    localparam int    DRAIN_CYCLES = 40;
    localparam int    WATCHDOG     = 2000;
    localparam longint XYZ_LIM     = longint'(16) << 16;
    localparam longint UNITY       = longint'(1) << 16;

    // Scoreboard: holds expected colors in request order and checks results.
    class color_scoreboard;
        result_t pending[$];
        int      errors;
        int      checked;

        function void note_request(result_t exp_color);
            pending.push_back(exp_color);
        endfunction

        function void check_color(result_t got);
            result_t exp_color;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result r=%0d g=%0d b=%0d c=%0b", $time,
                         got.red, got.green, got.blue, got.clipped);
                return;
            end
            exp_color = pending.pop_front();
            checked++;
            if (got.red !== exp_color.red)
            begin
                errors++;
                $display("%0t: red exp %0d got %0d", $time, exp_color.red, got.red);
            end
            if (got.green !== exp_color.green)
            begin
                errors++;
                $display("%0t: green exp %0d got %0d", $time, exp_color.green, got.green);
            end
            if (got.blue !== exp_color.blue)
            begin
                errors++;
                $display("%0t: blue exp %0d got %0d", $time, exp_color.blue, got.blue);
            end
            if (got.clipped !== exp_color.clipped)
            begin
                errors++;
                $display("%0t: clipped exp %0b got %0b", $time, exp_color.clipped,
                         got.clipped);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    request_t    request;
    logic        done;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    color_scoreboard sb;
    longint      curve[0:1024];
    logic [16:0] lum_setting;
    int          send_idle_pct;
    int          idle_cycles;
    bit          timed_out;
    int          clip_count;

    xyy_to_srgb_converter DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Rounding and clamping helpers: shifts round to nearest, ties away from zero.
    function automatic longint round_shift(longint v, int sh);
        if (sh == 0)
            return v;
        if (v < 0)
            return -((-v + (longint'(1) << (sh - 1))) >>> sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi, ref bit clip);
        if (v < lo)
        begin
            clip = 1'b1;
            return lo;
        end
        if (v > hi)
        begin
            clip = 1'b1;
            return hi;
        end
        return v;
    endfunction

    // Integer roots used to build the curve points independently.
    function automatic longint unsigned root2(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000000000000000;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned root3(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        for (int s = 63; s >= 0; s -= 3)
        begin
            r = r << 1;
            b = 3 * r * (r + 1) + 1;
            if ((x >> s) >= b)
            begin
                x = x - (b << s);
                r = r + 1;
            end
        end
        return r;
    endfunction

    task automatic build_curve();
        longint unsigned u;
        longint unsigned a;
        longint unsigned q;
        longint unsigned cb;
        longint unsigned p;
        longint          off;
        off = longint'(((64'd55 << 30) + 500) / 1000);
        for (int i = 0; i <= 1024; i++)
        begin
            u  = (longint'(i) << 30) / 1024;
            a  = root2(u << 30);
            q  = root2(a << 30);
            cb = root3((a >> 10) << 40);
            p  = (q * cb + (64'd1 << 19)) >> 20;
            curve[i] = round_shift(longint'((p * 1055 + 500) / 1000) - off, 14);
        end
    endtask

    function automatic longint matrix_coef(int r, int c);
        longint m [0:2][0:2];
        longint n;
        longint mag;
        m = '{'{32404500, -15371400, -4985320},
              '{-9692660, 18760100, 415561},
              '{556434, -2040260, 10572300}};
        n   = m[r][c];
        mag = ((n < 0 ? -n : n) * (longint'(1) << 30) + 5000000) / 10000000;
        return n < 0 ? -mag : mag;
    endfunction

    // The sRGB transfer curve: linear segment near black, table above it.
    function automatic longint srgb_encode(longint c, ref bit clip);
        longint thr;
        longint m;
        longint pos;
        longint idx;
        longint fr;
        thr = ((longint'(31308) << 16) + 5000000) / 10000000;
        if (c <= thr)
        begin
            m = c * 1292;
            return m < 0 ? -((-m + 50) / 100) : (m + 50) / 100;
        end
        if (c > UNITY)
        begin
            c    = UNITY;
            clip = 1'b1;
        end
        pos = c * 1024;
        idx = pos >>> 16;
        fr  = pos & 16'hFFFF;
        if (idx >= 1024)
            return curve[1024];
        return curve[idx] + round_shift((curve[idx + 1] - curve[idx]) * fr, 16);
    endfunction

    function automatic result_t predict_color(logic [16:0] cx, logic [16:0] cy,
                                              logic [16:0] lum);
        result_t         col;
        bit              clip;
        longint          xyz[3];
        longint unsigned den;
        longint          n;
        longint unsigned mag;
        longint          zm;
        longint          sum;
        longint          g;
        clip = 1'b0;
        if (cy == 0)
        begin
            xyz[0] = 0;
            xyz[2] = 0;
        end
        else
        begin
            den    = longint'(cy) << 16;
            n      = 65536 - longint'(cx) - longint'(cy);
            mag    = n < 0 ? -n : n;
            xyz[0] = ((longint'(lum) * cx << 16) + den / 2) / den;
            xyz[0] = clamp(xyz[0], -XYZ_LIM, XYZ_LIM - 1, clip);
            zm     = ((longint'(lum) * mag << 16) + den / 2) / den;
            xyz[2] = clamp(n < 0 ? -zm : zm, -XYZ_LIM, XYZ_LIM - 1, clip);
        end
        xyz[1] = lum;
        for (int k = 0; k < 3; k++)
        begin
            sum = 0;
            for (int j = 0; j < 3; j++)
                sum += xyz[j] * matrix_coef(k, j);
            g = srgb_encode(clamp(round_shift(sum, 30), -XYZ_LIM, XYZ_LIM - 1, clip), clip);
            g = clamp(g, -524288, 524287, clip);
            if (k == 0)
                col.red = g[19:0];
            else if (k == 1)
                col.green = g[19:0];
            else
                col.blue = g[19:0];
        end
        col.clipped = clip;
        return col;
    endfunction

    // Register write over the configuration port: setup then access cycle.
    task automatic write_luminance(logic [16:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_LUMINANCE;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        lum_setting = value;
    endtask

    // Present one request and hold it until the block takes it. The strobe
    // is only lowered after acceptance when an idle gap follows, so it is
    // never dropped and raised again within the same time step.
    task automatic send_request(logic [16:0] cx, logic [16:0] cy);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start           <= 1'b1;
        request.chroma_x <= cx;
        request.chroma_y <= cy;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(predict_color(cx, cy, lum_setting));
    endtask

    task automatic end_burst();
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Wait for every outstanding result, then let the pipeline settle.
    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Mostly plausible chromaticities, with full-range noise mixed in.
    task automatic random_request();
        logic [16:0] cx;
        logic [16:0] cy;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            cx = 17'($urandom_range(52000, 1000));
            cy = 17'($urandom_range(50000, 3000));
        end
        else if (pick < 70)
        begin
            cx = 17'($urandom_range(65536));
            cy = 17'($urandom_range(200));
        end
        else
        begin
            cx = 17'($urandom);
            cy = 17'($urandom);
        end
        send_request(cx, cy);
    endtask

    // Results are sampled at the edge that ends their single valid cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (result.clipped)
                clip_count++;
            sb.check_color(result);
        end
    end

    // Watchdog: a long stretch with no request or result taken is a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG && !timed_out)
        begin
            timed_out = 1'b1;
            $display("[xyy_to_srgb_converter] ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [16:0] lum_list[5];
        logic [16:0] edge_vals[6];
        int          idle_list[4];
        sb            = new();
        timed_out     = 1'b0;
        idle_cycles   = 0;
        clip_count    = 0;
        send_idle_pct = 0;
        lum_setting   = LUMINANCE_RESET;
        rst_n         = 1'b0;
        start         = 1'b0;
        request       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        build_curve();
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, zero y, values above one, white point.
        edge_vals = '{17'd0, 17'd1, 17'd65536, 17'h1FFFF, 17'd21846, 17'h15555};
        foreach (edge_vals[i])
            foreach (edge_vals[j])
                if (i < 4 || j < 4)
                    send_request(edge_vals[i], edge_vals[j]);
        send_request(17'd20495, 17'd21561);
        end_burst();
        drain();

        // Random phases across luminance settings and idle patterns,
        // including the register extremes and a value above one.
        lum_list  = '{17'd0, 17'd65536, 17'h1FFFF, 17'd1, 17'd30000};
        idle_list = '{0, 63, 0, 35};
        for (int p = 0; p < 5; p++)
        begin
            write_luminance(p == 4 ? 17'($urandom) : lum_list[p]);
            for (int s = 0; s < 4; s++)
            begin
                send_idle_pct = idle_list[s];
                for (int n = 0; n < 65; n++)
                    random_request();
                end_burst();
            end
            drain();
        end

        $display("Covered %0d results under five luminance settings, %0d clipped.",
                 sb.checked, clip_count);
        $display("Idle patterns: none, 63 and 35 percent on the request side.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[xyy_to_srgb_converter] OK");
        else
            $display("[xyy_to_srgb_converter] ERROR");
        $finish;
    end

endmodule

[xyy_to_srgb_converter.f]
rtl/xys_pkg.sv
rtl/xys_divider.sv
rtl/xys_matrix.sv
rtl/xys_gamma.sv
rtl/xyy_to_srgb_converter.sv
dv/tb_top.sv
